/* sv/i2p_pkg.sv */
package i2p_pkg;

    // Default number of operator stack entries.
    localparam int STACK_DEPTH = 16;

    // Character codes that the converter recognizes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_UPR_LO = 8'h41;
    localparam logic [7:0] CH_UPR_HI = 8'h5A;
    localparam logic [7:0] CH_LWR_LO = 8'h61;
    localparam logic [7:0] CH_LWR_HI = 8'h7A;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_END       = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW  = 2'd2;
    localparam logic [1:0] KIND_UNMATCHED = 2'd3;

    // Operator priorities.
    localparam logic [1:0] RANK_NONE = 2'd0;
    localparam logic [1:0] RANK_ADD  = 2'd1;
    localparam logic [1:0] RANK_MUL  = 2'd2;

    // Request from the sequencer to the result stage.
    typedef struct packed {
        logic       push;   // a new result is offered
        logic       fin;    // the current input has no more results
        logic [7:0] ch;
        logic [1:0] kind;
    } t_emit_req;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= CH_DIG_LO && c <= CH_DIG_HI) ||
               (c >= CH_UPR_LO && c <= CH_UPR_HI) ||
               (c >= CH_LWR_LO && c <= CH_LWR_HI);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
               c == CH_SLASH || c == CH_PCT;
    endfunction

    function automatic logic [1:0] rank(input logic [7:0] c);
        logic [1:0] r;
        r = RANK_NONE;
        if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) begin
            r = RANK_MUL;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            r = RANK_ADD;
        end
        return r;
    endfunction

endpackage

/* sv/i2p_if.sv */
// Infix character stream.
interface i2p_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

// Postfix result stream.
interface i2p_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic [1:0] kind;
    logic       last_of_run;

    modport source (output valid, output out_char, output kind, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_char, input kind, input last_of_run,
                    output ready);
endinterface

// Configuration write channel for the insert_space register.
interface i2p_cfg_if;
    logic valid;
    logic ready;
    logic insert_space;

    modport source (output valid, output insert_space, input ready);
    modport sink   (input valid, input insert_space, output ready);
endinterface

/* sv/i2p_ram.sv */
module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/i2p_emit.sv */
module i2p_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2p_pkg::t_emit_req  i_req,
    output logic                o_rdy,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_char,
    output logic [1:0]          o_kind,
    output logic                o_last
);

    // One result is held back until the next one, or the end of the input,
    // shows whether it was the last of its run.
    logic       r_pend_v;
    logic [7:0] r_pend_ch;
    logic [1:0] r_pend_kind;
    logic       r_out_v;
    logic [7:0] r_out_ch;
    logic [1:0] r_out_kind;
    logic       r_out_last;

    logic w_out_free;
    logic w_move;

    assign w_out_free = !r_out_v || i_ready;
    assign o_rdy      = !r_pend_v || w_out_free;
    assign w_move     = (i_req.push || i_req.fin) && r_pend_v && o_rdy;

    // Holding register and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_move) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_req.push && o_rdy) begin
                r_pend_v <= 1'b1;
            end else if (i_req.fin && o_rdy) begin
                r_pend_v <= 1'b0;
            end
        end
        if (w_move) begin
            r_out_ch   <= r_pend_ch;
            r_out_kind <= r_pend_kind;
            r_out_last <= i_req.fin;
        end
        if (i_req.push && o_rdy) begin
            r_pend_ch   <= i_req.ch;
            r_pend_kind <= i_req.kind;
        end
    end

    assign o_valid = r_out_v;
    assign o_char  = r_out_ch;
    assign o_kind  = r_out_kind;
    assign o_last  = r_out_last;

endmodule

/* sv/i2p_seq.sv */
module i2p_seq #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH,
    localparam int CW = $clog2(STACK_DEPTH + 1),
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [7:0]          i_in_char,
    output logic                o_in_ready,
    input  logic                i_insert_space,
    input  logic                i_emit_rdy,
    output i2p_pkg::t_emit_req  o_emit,
    output logic                o_ram_we,
    output logic [AW-1:0]       o_ram_waddr,
    output logic [7:0]          o_ram_wdata,
    output logic [AW-1:0]       o_ram_raddr,
    input  logic [7:0]          i_ram_rdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHAR, S_SPACE, S_DISPATCH, S_RD, S_EVAL, S_OP, S_OPSP,
        S_PUSH, S_OVF, S_END, S_UNM, S_FIN
    } t_state;

    typedef enum logic [2:0] {
        CLS_TERM, CLS_OPEN, CLS_CLOSE, CLS_OP, CLS_OTHER
    } t_cls;

    t_state     r_state, n_state;
    t_cls       r_cls, n_cls;
    logic [7:0] r_c, n_c;
    logic [7:0] r_t, n_t;
    logic [1:0] r_rank, n_rank;
    logic [CW-1:0] r_count, n_count;
    logic       r_in_op, n_in_op;

    logic [CW-1:0] w_cnt_m1;
    logic          w_stack_full;
    logic          w_rank_ge;

    assign w_cnt_m1     = r_count - CW'(1);
    assign w_stack_full = (r_count == CW'(STACK_DEPTH));
    // Priority compare: true when the stack top ranks at least as high as the incoming operator.
    assign w_rank_ge    = (i2p_pkg::rank(i_ram_rdata) >= r_rank);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        n_cls   = r_cls;
        n_c     = r_c;
        n_t     = r_t;
        n_rank  = r_rank;
        n_count = r_count;
        n_in_op = r_in_op;
        o_emit  = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_count[AW-1:0];
        o_ram_wdata = r_c;
        o_ram_raddr = w_cnt_m1[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_c    = i_in_char;
                    n_rank = i2p_pkg::rank(i_in_char);
                    if (i2p_pkg::is_alnum(i_in_char)) begin
                        n_in_op = 1'b1;
                        n_state = S_CHAR;
                    end else begin
                        n_in_op = 1'b0;
                        if (i_in_char == i2p_pkg::CH_NUL || i_in_char == i2p_pkg::CH_LF) begin
                            n_cls = CLS_TERM;
                        end else if (i_in_char == i2p_pkg::CH_LPAREN) begin
                            n_cls = CLS_OPEN;
                        end else if (i_in_char == i2p_pkg::CH_RPAREN) begin
                            n_cls = CLS_CLOSE;
                        end else if (i2p_pkg::is_op(i_in_char)) begin
                            n_cls = CLS_OP;
                        end else begin
                            n_cls = CLS_OTHER;
                        end
                        n_state = (r_in_op && i_insert_space) ? S_SPACE : S_DISPATCH;
                    end
                end
            end
            S_CHAR: begin
                o_emit.push = 1'b1;
                o_emit.ch   = r_c;
                o_emit.kind = i2p_pkg::KIND_CHAR;
                if (i_emit_rdy) begin
                    n_state = S_FIN;
                end
            end
            S_SPACE: begin
                o_emit.push = 1'b1;
                o_emit.ch   = i2p_pkg::CH_SPACE;
                o_emit.kind = i2p_pkg::KIND_CHAR;
                if (i_emit_rdy) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (r_cls) inside
                    CLS_TERM, CLS_CLOSE, CLS_OP: n_state = S_RD;
                    CLS_OPEN:                    n_state = S_PUSH;
                    default:                     n_state = S_FIN;
                endcase
            end
            // The stack top is read here and seen in S_EVAL.
            S_RD: begin
                if (r_count == '0) begin
                    case (r_cls)
                        CLS_TERM:  n_state = S_END;
                        CLS_CLOSE: n_state = S_UNM;
                        default:   n_state = S_PUSH;
                    endcase
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_cls == CLS_CLOSE && i_ram_rdata == i2p_pkg::CH_LPAREN) begin
                    n_count = w_cnt_m1;
                    n_state = S_FIN;
                end else if (r_cls == CLS_OP && !w_rank_ge) begin
                    n_state = S_PUSH;
                end else begin
                    n_count = w_cnt_m1;
                    n_t     = i_ram_rdata;
                    n_state = S_OP;
                end
            end
            S_OP: begin
                o_emit.push = 1'b1;
                o_emit.ch   = r_t;
                o_emit.kind = i2p_pkg::KIND_CHAR;
                if (i_emit_rdy) begin
                    n_state = i_insert_space ? S_OPSP : S_RD;
                end
            end
            S_OPSP: begin
                o_emit.push = 1'b1;
                o_emit.ch   = i2p_pkg::CH_SPACE;
                o_emit.kind = i2p_pkg::KIND_CHAR;
                if (i_emit_rdy) begin
                    n_state = S_RD;
                end
            end
            S_PUSH: begin
                if (w_stack_full) begin
                    n_state = S_OVF;
                end else begin
                    o_ram_we = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_state  = S_FIN;
                end
            end
            S_OVF: begin
                o_emit.push = 1'b1;
                o_emit.kind = i2p_pkg::KIND_OVERFLOW;
                if (i_emit_rdy) begin
                    n_state = S_FIN;
                end
            end
            S_END: begin
                o_emit.push = 1'b1;
                o_emit.kind = i2p_pkg::KIND_END;
                if (i_emit_rdy) begin
                    n_state = S_FIN;
                end
            end
            S_UNM: begin
                o_emit.push = 1'b1;
                o_emit.kind = i2p_pkg::KIND_UNMATCHED;
                if (i_emit_rdy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_emit.fin = 1'b1;
                if (i_emit_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_in_op <= 1'b0;
            r_cls   <= CLS_OTHER;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_in_op <= n_in_op;
            r_cls   <= n_cls;
        end
        r_c    <= n_c;
        r_t    <= n_t;
        r_rank <= n_rank;
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* sv/infix_to_postfix_converter_core.sv */
// Channel  Dir  Beat contents                      Handshake
// i_in     in   in_char                            valid / ready
// o_out    out  out_char, kind, last_of_run        valid / ready
// i_cfg    in   insert_space                       valid / ready (ready always high)
//
// One input character is taken at a time; ready is high only while the sequencer idles.
// A letter or digit passes through the char and finish states; other characters go
// through dispatch, and each popped operator through a stack read, an evaluate step and
// an emit step (and a space step with spacing on), as the registered RAM read requires.
// Reset is synchronous and active low; it empties the stack and sets insert_space to 1.
// A stalled output holds the sequencer only when its holding register is also full.
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2p_char_if.sink      i_in,
    i2p_res_if.source     o_out,
    i2p_cfg_if.sink       i_cfg
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic               r_insert_space;
    i2p_pkg::t_emit_req w_emit;
    logic               w_emit_rdy;
    logic               w_ram_we;
    logic [AW-1:0]      w_ram_waddr;
    logic [7:0]         w_ram_wdata;
    logic [AW-1:0]      w_ram_raddr;
    logic [7:0]         w_ram_rdata;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_insert_space <= 1'b1;
        end else if (i_cfg.valid) begin
            r_insert_space <= i_cfg.insert_space;
        end
    end

    assign i_cfg.ready = 1'b1;

    // Sequencer for classification, stack pops and pushes.
    i2p_seq #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .i_in_char      (i_in.in_char),
        .o_in_ready     (i_in.ready),
        .i_insert_space (r_insert_space),
        .i_emit_rdy     (w_emit_rdy),
        .o_emit         (w_emit),
        .o_ram_we       (w_ram_we),
        .o_ram_waddr    (w_ram_waddr),
        .o_ram_wdata    (w_ram_wdata),
        .o_ram_raddr    (w_ram_raddr),
        .i_ram_rdata    (w_ram_rdata)
    );

    // Operator stack storage.
    i2p_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Result holding and output registers.
    i2p_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_emit),
        .o_rdy   (w_emit_rdy),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_char  (o_out.out_char),
        .o_kind  (o_out.kind),
        .o_last  (o_out.last_of_run)
    );

endmodule

/* sv/i2p_checker.sv */
module i2p_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic [1:0] i_out_kind,
    input logic       i_out_last
);

    // A stalled result beat holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_char) && $stable(i_out_kind) && $stable(i_out_last))
        else $error("result beat changed while stalled");

    // Markers carry no character.
    a_marker_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != i2p_pkg::KIND_CHAR |-> i_out_char == 8'h00)
        else $error("marker result with nonzero character");

    // End, overflow and unmatched markers always close the run of their input.
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != i2p_pkg::KIND_CHAR |-> i_out_last)
        else $error("marker result not marked last");

    // The converter works on one character at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a character is in progress");

    // No result appears right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind infix_to_postfix_converter_core i2p_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_kind  (o_out.kind),
    .i_out_last  (o_out.last_of_run)
);
